// File: src/chs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the compass heading smoother.
// Used by chs_ctrl, chs_datapath and compass_heading_smoother; has no dependencies.

package chs_pkg;

    localparam int MAG_W      = 16;   // sample and offset width
    localparam int GAIN_W     = 16;   // Q0.16 smoothing gain
    localparam int OUT_W      = 12;   // heading in tenths of a degree
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TABLE_BITS = 24;   // fraction bits of the arctangent table
    localparam int ATAN_W     = 30;   // width of one table entry

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ITER,
        S_FIN,
        S_DIFF,
        S_WRAP,
        S_MUL,
        S_UPD_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic iter;
        logic fin;
        logic diff;
        logic wrap;
        logic mul;
        logic upd;
    } t_dp_cmd;

    typedef struct packed {
        logic special;
        logic last_iter;
    } t_dp_sts;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic [ATAN_W-1:0] atan_deg_q24(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 30'd754974720;
            5'd1:    v = 30'd445687602;
            5'd2:    v = 30'd235489088;
            5'd3:    v = 30'd119537938;
            5'd4:    v = 30'd60000934;
            5'd5:    v = 30'd30029717;
            5'd6:    v = 30'd15018523;
            5'd7:    v = 30'd7509720;
            5'd8:    v = 30'd3754917;
            5'd9:    v = 30'd1877466;
            5'd10:   v = 30'd938734;
            5'd11:   v = 30'd469367;
            5'd12:   v = 30'd234684;
            5'd13:   v = 30'd117342;
            5'd14:   v = 30'd58671;
            5'd15:   v = 30'd29335;
            5'd16:   v = 30'd14668;
            5'd17:   v = 30'd7334;
            5'd18:   v = 30'd3667;
            5'd19:   v = 30'd1833;
            5'd20:   v = 30'd917;
            5'd21:   v = 30'd458;
            5'd22:   v = 30'd229;
            5'd23:   v = 30'd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/chs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the compass heading smoother: steps the datapath through
// offset removal, CORDIC iterations, smoothing and output. Depends on chs_pkg.

module chs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  chs_pkg::t_dp_sts  i_sts,
    output chs_pkg::t_dp_cmd  o_cmd
);

    chs_pkg::t_state r_state;
    chs_pkg::t_state n_state;
    logic            r_valid;
    logic            n_valid;
    logic            w_out_free;

    assign w_out_free = !r_valid || !i_stall;
    assign o_stall    = (r_state != chs_pkg::S_IDLE);
    assign o_valid    = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chs_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_valid = r_valid && i_stall;
        unique case (r_state)
            chs_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = chs_pkg::S_PREP;
                end
            end
            chs_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                // vectors with a zero Y component, the zero vector included, skip the rotation
                n_state    = i_sts.special ? chs_pkg::S_FIN : chs_pkg::S_ITER;
            end
            chs_pkg::S_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_sts.last_iter) begin
                    n_state = chs_pkg::S_FIN;
                end
            end
            chs_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = chs_pkg::S_DIFF;
            end
            chs_pkg::S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = chs_pkg::S_WRAP;
            end
            chs_pkg::S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = chs_pkg::S_MUL;
            end
            chs_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = chs_pkg::S_UPD_OUT;
            end
            chs_pkg::S_UPD_OUT: begin
                // hold until the previous result is taken, then update and present
                if (w_out_free) begin
                    o_cmd.upd = 1'b1;
                    n_valid   = 1'b1;
                    n_state   = chs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = chs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/chs_datapath.sv
`timescale 1ns / 1ps
// Datapath of the compass heading smoother: offset removal, iterative CORDIC,
// angle wrap, gain multiply, smoothed heading state and output. Depends on chs_pkg.

module chs_datapath #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  chs_pkg::t_dp_cmd                    i_cmd,
    output chs_pkg::t_dp_sts                    o_sts,
    input  logic signed [chs_pkg::MAG_W-1:0]    i_mag_x,
    input  logic signed [chs_pkg::MAG_W-1:0]    i_mag_y,
    input  logic signed [chs_pkg::MAG_W-1:0]    i_offset_x,
    input  logic signed [chs_pkg::MAG_W-1:0]    i_offset_y,
    input  logic        [chs_pkg::GAIN_W-1:0]   i_gain,
    output logic        [chs_pkg::OUT_W-1:0]    o_heading_tenths
);

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int HW  = F + 11;              // signed heading and difference
    localparam int SW  = F + 9;               // smoothed heading, [0,360)
    localparam int MW  = F + 9;               // magnitude of the wrapped difference
    localparam int PW  = MW + chs_pkg::GAIN_W;
    localparam int TW  = SW + 3;              // heading times ten
    localparam int CW  = chs_pkg::MAG_W + 1;  // corrected component
    localparam int NW  = CW + 1;
    localparam int XW  = NW + chs_pkg::TABLE_BITS + 2;
    localparam int ZW  = 33;
    localparam int IW  = $clog2(CORDIC_STEPS);
    localparam int ZSH = chs_pkg::TABLE_BITS - F;

    localparam logic signed [HW-1:0] K180 = HW'(180) <<< F;
    localparam logic signed [HW-1:0] K360 = HW'(360) <<< F;

    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic        [IW-1:0] r_i;
    logic signed [HW-1:0] r_base;
    logic signed [HW-1:0] r_head;
    logic signed [HW-1:0] r_diff;
    logic        [MW-1:0] r_mag;
    logic                 r_neg;
    logic        [PW-1:0] r_prod;
    logic        [SW-1:0] r_smooth;

    logic signed [NW-1:0] w_cx_ext;
    logic signed [NW-1:0] w_cy_ext;
    logic signed [NW-1:0] w_x0;
    logic signed [NW-1:0] w_y0;
    logic signed [HW-1:0] w_base;
    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [ZW-1:0] w_atan;
    logic signed [HW-1:0] w_wrap;
    logic signed [HW-1:0] w_abs;
    logic        [MW-1:0] w_step;
    logic signed [HW-1:0] w_sum;
    logic signed [HW-1:0] w_sum_wrap;
    logic        [TW-1:0] w_ten;

    assign o_sts.special   = (r_cy == '0);
    assign o_sts.last_iter = (r_i == IW'(CORDIC_STEPS - 1));

    // quadrant fold: left half-plane is rotated by half a turn
    always_comb begin
        w_cx_ext = NW'(r_cx);
        w_cy_ext = NW'(r_cy);
        if (r_cy == '0) begin
            w_x0   = w_cx_ext;
            w_y0   = w_cy_ext;
            w_base = (r_cx < 0) ? K360 : K180;
        end else if (r_cx < 0) begin
            w_x0   = -w_cx_ext;
            w_y0   = -w_cy_ext;
            w_base = (r_cy > 0) ? K360 : '0;
        end else begin
            w_x0   = w_cx_ext;
            w_y0   = w_cy_ext;
            w_base = K180;
        end
    end

    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = ZW'(chs_pkg::atan_deg_q24(5'(r_i)));

    always_comb begin
        if (r_diff > K180) begin
            w_wrap = r_diff - K360;
        end else if (r_diff < -K180) begin
            w_wrap = r_diff + K360;
        end else begin
            w_wrap = r_diff;
        end
        w_abs = (w_wrap < 0) ? -w_wrap : w_wrap;
    end

    assign w_step = r_prod[PW-1:chs_pkg::GAIN_W];

    always_comb begin
        if (r_neg) begin
            w_sum = $signed(HW'(r_smooth)) - $signed(HW'(w_step));
        end else begin
            w_sum = $signed(HW'(r_smooth)) + $signed(HW'(w_step));
        end
        if (w_sum >= K360) begin
            w_sum_wrap = w_sum - K360;
        end else if (w_sum < 0) begin
            w_sum_wrap = w_sum + K360;
        end else begin
            w_sum_wrap = w_sum;
        end
    end

    assign w_ten = TW'({r_smooth, 3'b000}) + TW'({r_smooth, 1'b0});

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cx <= CW'(i_mag_x) - CW'(i_offset_x);
            r_cy <= CW'(i_mag_y) - CW'(i_offset_y);
        end
        if (i_cmd.prep) begin
            r_x    <= XW'(w_x0) <<< chs_pkg::TABLE_BITS;
            r_y    <= XW'(w_y0) <<< chs_pkg::TABLE_BITS;
            r_z    <= '0;
            r_i    <= '0;
            r_base <= w_base;
        end else if (i_cmd.iter) begin
            // rotate toward the x axis
            if (r_y > 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.fin) begin
            r_head <= r_base + HW'(r_z >>> ZSH);
        end
        if (i_cmd.diff) begin
            r_diff <= r_head - $signed(HW'(r_smooth));
        end
        if (i_cmd.wrap) begin
            r_mag <= w_abs[MW-1:0];
            r_neg <= (w_wrap < 0);
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_mag) * PW'(i_gain);
        end
    end

    // smoothed heading state; it only moves once the previous result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
        end else if (i_cmd.upd) begin
            r_smooth <= w_sum_wrap[SW-1:0];
        end
    end

    assign o_heading_tenths = w_ten[F+chs_pkg::OUT_W-1:F];

endmodule

// File: src/compass_heading_smoother.sv
`timescale 1ns / 1ps
// Top level of the compass heading smoother: configuration registers, sequencer
// and datapath. Depends on chs_pkg, chs_ctrl and chs_datapath.
//
// Usage:
//   Input channel: i_valid, i_mag_x, i_mag_y; the block drives o_stall. A sample
//   is taken at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid, o_heading_tenths; the receiver drives i_stall.
//   Each sample gives one smoothed heading, 0 to 3599 tenths of a degree.
//   After acceptance the sample steps through PREP, ITER (skipped when the
//   corrected Y component is zero), FIN, DIFF, WRAP, MUL and UPD_OUT. One sample is
//   processed at a time; the iterative CORDIC, one step per cycle, sets the
//   rate, so a new sample is taken only once the block is back in IDLE.
//   A finished result is held on the output while the next sample is taken;
//   if the receiver still stalls when the following result is ready,
//   the block holds that result and keeps o_stall high until the slot frees.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 offset_x, 1 offset_y, 2 smoothing_gain); other indexes are ignored.
//   Write only while the block is idle.
//   Reset (synchronous, active low): offsets 48 and -216, gain 9830, smoothed
//   heading zero, no result pending.

module compass_heading_smoother #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [chs_pkg::MAG_W-1:0]      i_mag_x,
    input  logic signed [chs_pkg::MAG_W-1:0]      i_mag_y,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic        [chs_pkg::OUT_W-1:0]      o_heading_tenths,
    input  logic                                  i_cfg_we,
    input  logic        [chs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [chs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic signed [chs_pkg::MAG_W-1:0]  r_offset_x;
    logic signed [chs_pkg::MAG_W-1:0]  r_offset_y;
    logic        [chs_pkg::GAIN_W-1:0] r_gain;
    chs_pkg::t_dp_cmd                  w_cmd;
    chs_pkg::t_dp_sts                  w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= 16'sd48;
            r_offset_y <= -16'sd216;
            r_gain     <= 16'd9830;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                chs_pkg::CFG_OFFSET_X: r_offset_x <= $signed(i_cfg_data);
                chs_pkg::CFG_OFFSET_Y: r_offset_y <= $signed(i_cfg_data);
                chs_pkg::CFG_GAIN:     r_gain     <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    chs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    chs_datapath #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_mag_x          (i_mag_x),
        .i_mag_y          (i_mag_y),
        .i_offset_x       (r_offset_x),
        .i_offset_y       (r_offset_y),
        .i_gain           (r_gain),
        .o_heading_tenths (o_heading_tenths)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block took a sample but did not go busy");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading_tenths <= 12'd3599))
        else $error("heading out of range");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result presented right after reset");

    a_result_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while the block was idle");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for compass_heading_smoother: directed and random magnetometer samples,
// checked against a bit-exact heading predictor, with random idling on both sides.
// Depends on chs_pkg and the compass_heading_smoother RTL.

module testbench;

    localparam int     MAG_W       = chs_pkg::MAG_W;
    localparam int     OUT_W       = chs_pkg::OUT_W;
    localparam int     CFG_IDX_W   = chs_pkg::CFG_IDX_W;
    localparam int     CFG_DATA_W  = chs_pkg::CFG_DATA_W;
    localparam int     TABLE_BITS  = chs_pkg::TABLE_BITS;
    localparam int     FRAC        = 16;
    localparam int     STEPS       = 16;
    localparam longint DEG180      = 64'sd180 <<< FRAC;
    localparam longint DEG360      = 64'sd360 <<< FRAC;
    localparam int     IDLE_LIMIT  = 4000;
    localparam int     SETTLE      = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = chs_pkg::CFG_OFFSET_X;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = chs_pkg::CFG_OFFSET_Y;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = chs_pkg::CFG_GAIN;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam longint ATAN_Q24 [0:23] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [MAG_W-1:0]      mag_x    = '0;
    logic [MAG_W-1:0]      mag_y    = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [OUT_W-1:0]      heading;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state and register mirror
    longint smooth_hdg = 0;
    longint cal_off_x  = 48;
    longint cal_off_y  = -216;
    longint cal_gain   = 9830;

    logic [OUT_W-1:0] heading_expected_q[$];
    int  n_errors    = 0;
    int  idle_cycles = 0;
    int  rx_hold     = 0;
    bit  tx_calm     = 1'b0;
    bit  rx_calm     = 1'b0;
    bit  rx_heavy    = 1'b0;

    compass_heading_smoother uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_mag_x          (mag_x),
        .i_mag_y          (mag_y),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_heading_tenths (heading),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // atan2(y,x) + 180 degrees, Q9.16
    function automatic longint cordic_heading(longint cx, longint cy);
        longint x, y, z, xs, ys, base;
        z = 0;
        if (cx == 0 && cy == 0) return DEG180;
        if (cy == 0) return (cx > 0) ? DEG180 : DEG360;
        if (cx < 0) begin
            base = (cy > 0) ? DEG360 : 64'sd0;
            x = -cx;
            y = -cy;
        end else begin
            base = DEG180;
            x = cx;
            y = cy;
        end
        x = x <<< TABLE_BITS;
        y = y <<< TABLE_BITS;
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q24[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q24[i];
            end
        end
        return base + (z >>> (TABLE_BITS - FRAC));
    endfunction

    // move the smoothed heading toward one sample, return it in tenths
    function automatic logic [OUT_W-1:0] advance_heading(logic [MAG_W-1:0] sx,
                                                         logic [MAG_W-1:0] sy);
        longint diff, mag, stp;
        diff = cordic_heading(longint'($signed(sx)) - cal_off_x,
                              longint'($signed(sy)) - cal_off_y) - smooth_hdg;
        if (diff > DEG180) diff -= DEG360;
        if (diff < -DEG180) diff += DEG360;
        mag = (diff < 0) ? -diff : diff;
        stp = (mag * cal_gain) >>> 16;
        if (diff < 0) stp = -stp;
        smooth_hdg += stp;
        if (smooth_hdg >= DEG360) smooth_hdg -= DEG360;
        if (smooth_hdg < 0) smooth_hdg += DEG360;
        return OUT_W'((smooth_hdg * 10) >>> FRAC);
    endfunction

    // mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 15);
        return $urandom_range(30, 150);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic send_sample(input logic [MAG_W-1:0] x, input logic [MAG_W-1:0] y);
        int gap;
        in_valid <= 1'b1;
        mag_x    <= x;
        mag_y    <= y;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        heading_expected_q.push_back(advance_heading(x, y));
        gap = (tx_calm || $urandom_range(0, 1)) ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and hold until every pending heading has come out
    task automatic wait_results();
        in_valid <= 1'b0;
        while (heading_expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic wait_drained();
        wait_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_OFFSET_X: cal_off_x = longint'($signed(data));
            CFG_OFFSET_Y: cal_off_y = longint'($signed(data));
            CFG_GAIN:     cal_gain  = longint'(data);
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] ox, input logic [15:0] oy, input logic [15:0] g);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_GAIN, g);
    endtask

    task automatic pick_sample(output logic [MAG_W-1:0] x, output logic [MAG_W-1:0] y);
        int r, amp;
        r   = $urandom_range(0, 99);
        amp = $urandom_range(0, 1) ? 4000 : 300;
        if (r < 70) begin
            // plausible field around the hard-iron offset
            x = MAG_W'(cal_off_x + longint'($urandom_range(0, 2 * amp)) - amp);
            y = MAG_W'(cal_off_y + longint'($urandom_range(0, 2 * amp)) - amp);
        end else if (r < 80) begin
            // corrected Y exactly zero, sometimes the zero vector
            x = $urandom_range(0, 3) == 0 ? MAG_W'(cal_off_x) : MAG_W'($urandom);
            y = MAG_W'(cal_off_y);
        end else begin
            x = MAG_W'($urandom);
            y = MAG_W'($urandom);
        end
    endtask

    task automatic send_random(input int count);
        logic [MAG_W-1:0] x, y;
        repeat (count) begin
            pick_sample(x, y);
            send_sample(x, y);
        end
    endtask

    task automatic test_special_cases();
        send_sample(16'sd48, -16'sd216);     // zero vector
        send_sample(16'sd1048, -16'sd216);   // Y zero, X positive
        send_sample(-16'sd952, -16'sd216);   // Y zero, X negative: 360
        send_sample(16'sd48, 16'sd784);
        send_sample(16'sd48, -16'sd1216);
        wait_drained();
    endtask

    task automatic test_extremes();
        write_all(16'h0000, 16'h0000, 16'hFFFF);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h0000, 16'h0001);
        send_sample(16'hFFFF, 16'h0000);
        wait_drained();
        // corrected components at full 17-bit reach
        write_all(16'h8000, 16'h7FFF, 16'hFFFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF);
        wait_drained();
        write_all(16'h7FFF, 16'h8000, 16'hFFFF);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        wait_drained();
        // jumps across north, beyond half a turn both ways
        write_all(16'h0000, 16'h0000, 16'hFFFF);
        send_sample(-16'sd985, -16'sd174);
        send_sample(-16'sd985, 16'sd174);
        send_sample(-16'sd985, -16'sd174);
        wait_drained();
        // zero gain holds the heading
        write_reg(CFG_GAIN, 16'h0000);
        send_sample(16'sd500, 16'sd500);
        send_sample(-16'sd500, 16'sd20);
        wait_drained();
        // unused index must leave every register alone
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_GAIN, 16'd9830);
        write_reg(CFG_UNUSED, 16'h0000);
        send_sample(16'sd200, -16'sd300);
        wait_drained();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            tx_calm = (p == 4);
            rx_calm = (p == 4);
            case (p)
                0: write_all(16'(int'($urandom_range(0, 2048)) - 1024),
                             16'(int'($urandom_range(0, 2048)) - 1024), 16'd9830);
                1: write_all(16'(int'($urandom_range(0, 2048)) - 1024),
                             16'(int'($urandom_range(0, 2048)) - 1024), 16'hFFFF);
                2: write_all(16'(int'($urandom_range(0, 2048)) - 1024),
                             16'(int'($urandom_range(0, 2048)) - 1024), 16'd1);
                3: write_all(16'h8000, 16'h7FFF, 16'($urandom));
                4: write_all(16'h7FFF, 16'h8000, 16'($urandom));
                default: write_all(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            send_random(100);
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_all(16'sd48, -16'sd216, 16'd9830);
        send_random(10);
        // sender holds off until all headings are out
        wait_results();
        send_random(10);
        // back-to-back samples against a stalling receiver
        tx_calm  = 1'b1;
        rx_heavy = 1'b1;
        send_random(20);
        tx_calm  = 1'b0;
        rx_heavy = 1'b0;
        wait_drained();
    endtask

    always @(posedge clk) begin
        logic [OUT_W-1:0] want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (heading_expected_q.size() == 0) begin
                    report_mismatch($sformatf("heading %0d with no sample pending", heading));
                end else begin
                    want = heading_expected_q.pop_front();
                    if (heading !== want)
                        report_mismatch($sformatf("heading got %0d want %0d", heading, want));
                end
            end
            if (rx_hold > 0) begin
                out_stall <= 1'b1;
                rx_hold--;
            end else if (!rx_calm && $urandom_range(0, 99) < (rx_heavy ? 60 : 20)) begin
                out_stall <= 1'b1;
                rx_hold = gap_len() - 1;
            end else begin
                out_stall <= 1'b0;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** compass_heading_smoother: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_extremes();
        test_random_phases();
        test_backpressure();
        if (n_errors == 0)
            $display("** compass_heading_smoother: PASSED **");
        else
            $display("** compass_heading_smoother: FAILED **");
        $finish;
    end

endmodule
